// ----- sv/hltg_pkg.sv -----
// Shared constants, codes and types of the HighLife tile generation unit.
package hltg_pkg;

  localparam int BOARD_SIDE = 8;
  localparam int CELL_W     = 5;
  localparam int CELL_MAX   = 31;
  localparam int GROWTH     = 8;
  localparam int HIGH_BIRTH = 6;
  localparam int ADDR_W     = 3;
  localparam int EDGE_W     = 8;
  localparam int EDGE_IDX_W = $clog2(EDGE_W);
  localparam int BSUM_W     = 11;
  localparam int STEADY_W   = 8;
  localparam int GEN_W      = 12;
  localparam int ROW_W      = $clog2(BOARD_SIDE);
  localparam int SUM_W      = $clog2(BOARD_SIDE * BOARD_SIDE * CELL_MAX + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [STEADY_W-1:0] STASIS_RESET  = 8'd50;
  localparam logic [GEN_W-1:0]    GEN_LIM_RESET = 12'd1000;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_HALO  = 3'd1,
    OP_STEP  = 3'd2,
    OP_READ  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGHLIFE = 3'd0,
    CFG_MONO     = 3'd1,
    CFG_STASIS   = 3'd2,
    CFG_GEN_LIM  = 3'd3,
    CFG_REVERSE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_SUM,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  // Live bits that one lane shows its neighbors for the row under update.
  typedef struct packed {
    logic above;
    logic cur;
    logic below;
  } nbr_t;

  // Control shared by every lane of the chain.
  typedef struct packed {
    logic              shift;
    logic              first;
    logic              last;
    logic              clear;
    logic              highlife;
    logic              mono;
    logic [ROW_W-1:0]  row;
    logic [CELL_W-1:0] wr_data;
  } lane_ctrl_t;

endpackage

// ----- sv/hltg_lane.sv -----
// One column lane of the tile: holds a column of cells and applies the rule row by row.
module hltg_lane
  import hltg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lane_ctrl_t            ctrl,
  input  logic                  wr_en,
  input  nbr_t                  left_nbr,
  input  nbr_t                  right_nbr,
  input  logic                  top_halo,
  input  logic                  bottom_halo,
  output nbr_t                  own_nbr,
  output logic [CELL_W-1:0]     rd_value,
  output logic [CELL_W-1:0]     tail_value,
  output logic [BOARD_SIDE-1:0] live
);

  logic [CELL_W-1:0] col_r [BOARD_SIDE];
  logic              above_r;
  logic              cur_live;
  logic              below_live;
  logic              above_live;
  logic [3:0]        cnt;
  logic              next_live;
  logic [CELL_W:0]   grown;
  logic [CELL_W-1:0] new_value;

  // The head of the column is the row being updated; the next entry is the row below.
  assign cur_live   = (col_r[0] != '0);
  assign below_live = ctrl.last ? bottom_halo : (col_r[1] != '0);
  assign above_live = ctrl.first ? top_halo : above_r;
  assign own_nbr    = '{above: above_live, cur: cur_live, below: below_live};

  always_comb begin
    cnt = 4'(above_live) + 4'(below_live)
        + 4'(left_nbr.above) + 4'(left_nbr.cur) + 4'(left_nbr.below)
        + 4'(right_nbr.above) + 4'(right_nbr.cur) + 4'(right_nbr.below);
    if (cnt == 4'd2) begin
      next_live = cur_live;
    end else if (cnt == 4'd3) begin
      next_live = 1'b1;
    end else if (cnt == 4'(HIGH_BIRTH)) begin
      next_live = ctrl.highlife;
    end else begin
      next_live = 1'b0;
    end
    grown = {1'b0, col_r[0]} + (CELL_W + 1)'(GROWTH);
    if (!next_live) begin
      new_value = '0;
    end else if (ctrl.mono || grown > (CELL_W + 1)'(CELL_MAX)) begin
      new_value = CELL_W'(CELL_MAX);
    end else begin
      new_value = grown[CELL_W-1:0];
    end
  end

  // During a step the column rotates: the updated head goes to the tail.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BOARD_SIDE; i++) col_r[i] <= '0;
      above_r <= 1'b0;
    end else if (ctrl.clear) begin
      for (int i = 0; i < BOARD_SIDE; i++) col_r[i] <= '0;
    end else if (ctrl.shift) begin
      for (int i = 0; i < BOARD_SIDE - 1; i++) col_r[i] <= col_r[i+1];
      col_r[BOARD_SIDE-1] <= new_value;
      above_r <= cur_live;
    end else if (wr_en) begin
      col_r[ctrl.row] <= ctrl.wr_data;
    end
  end

  assign rd_value   = col_r[ctrl.row];
  assign tail_value = col_r[BOARD_SIDE-1];

  always_comb begin
    for (int i = 0; i < BOARD_SIDE; i++) live[i] = (col_r[i] != '0);
  end

endmodule

// ----- sv/highlife_tile_generation_unit.sv -----
// Top level of the HighLife tile generation unit: command sequencer, halo and lane chain.
//
// The unit holds one square tile of a Life or HighLife automaton as a chain of column
// lanes, one lane per column, each keeping its column of 5-bit brightness values. Every
// input transfer carries one operation and yields exactly one result transfer that shows
// the tile after the operation. A write, halo load, read, clear or undefined operation
// goes from the execute state straight to the result state; a step first sweeps the
// board, the lanes updating it one row per cycle and rotating their columns, then
// closes the sum in the sum state and applies the clear rules in the decide state.
// A new operation is taken once the previous one has produced its result, even while
// that result still waits in the output register. The board resets at once, so no
// clearing pass follows reset. Configuration must be written through the cfg port
// only while idle (the unit does not check this); writes to unused indexes are ignored.
module highlife_tile_generation_unit
  import hltg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, from bit 0: cell_col[3], cell_row[3], write_value[5], edge_select[2],
  // edge_bits[8], zero fill to 24 bits.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,
  // in_tuser: operation[3].
  input  logic [2:0]            in_tuser,
  // out_tdata, from bit 0: read_value[5], brightness_sum[11], steady_count[8],
  // board_cleared[1], out_edge_top[8], out_edge_right[8], out_edge_bottom[8],
  // out_edge_left[8], zero fill to 64 bits.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(BOARD_SIDE - 1);

  // Reverses the bit order of an incoming halo edge.
  function automatic logic [EDGE_W-1:0] flip_edge(input logic [EDGE_W-1:0] v);
    logic [EDGE_W-1:0] r;
    for (int i = 0; i < EDGE_W; i++) r[i] = v[EDGE_W-1-i];
    return r;
  endfunction

  // Halo positions off the board, beyond the edge width or at the corners are dead.
  function automatic logic halo_bit(input logic [EDGE_W-1:0] mask, input int pos);
    logic b;
    b = 1'b0;
    if (pos >= 0 && pos < EDGE_W && pos < BOARD_SIDE) b = mask[pos[EDGE_IDX_W-1:0]];
    return b;
  endfunction

  // Configuration registers.
  logic                highlife_r;
  logic                mono_r;
  logic [STEADY_W-1:0] stasis_r;
  logic [GEN_W-1:0]    gen_limit_r;
  logic [3:0]          reverse_r;

  // Sequencer and bookkeeping state.
  state_t              state_r, state_nxt;
  op_t                 cmd_op_r;
  logic [ADDR_W-1:0]   cmd_col_r;
  logic [ADDR_W-1:0]   cmd_row_r;
  logic [CELL_W-1:0]   cmd_wval_r;
  logic [1:0]          cmd_esel_r;
  logic [EDGE_W-1:0]   cmd_ebits_r;
  logic [ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]    prior_r, prior_nxt;
  logic [STEADY_W-1:0] steady_r, steady_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [BSUM_W-1:0]   bsum_r, bsum_nxt;
  logic                cleared_r, cleared_nxt;
  logic [EDGE_W-1:0]   halo_r [4];
  logic [EDGE_W-1:0]   halo_nxt [4];

  // Result register.
  logic                out_valid_r;
  logic [63:0]         out_data_r;
  logic                out_load;

  // Lane chain.
  lane_ctrl_t          lane_ctrl;
  logic                lane_clear;
  logic                lane_shift;
  logic                wr_go;
  logic                addr_ok;
  nbr_t                lane_nbr [BOARD_SIDE];
  logic [CELL_W-1:0]   lane_rd [BOARD_SIDE];
  logic [CELL_W-1:0]   lane_tail [BOARD_SIDE];
  logic [BOARD_SIDE-1:0] lane_live [BOARD_SIDE];
  nbr_t                left_halo_nbr;
  nbr_t                right_halo_nbr;
  logic [SUM_W-1:0]    tail_sum;
  logic                any_live;

  // Step decision terms.
  logic                sum_same;
  logic [CELL_W-1:0]   rd_sel;
  logic [EDGE_W-1:0]   edge_top, edge_right, edge_bottom, edge_left;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign addr_ok = (int'(cmd_col_r) < BOARD_SIDE) && (int'(cmd_row_r) < BOARD_SIDE);

  always_comb begin
    lane_ctrl.shift    = lane_shift;
    lane_ctrl.first    = (row_cnt_r == '0);
    lane_ctrl.last     = (row_cnt_r == ROW_LAST);
    lane_ctrl.clear    = lane_clear;
    lane_ctrl.highlife = highlife_r;
    lane_ctrl.mono     = mono_r;
    lane_ctrl.row      = ROW_W'(cmd_row_r);
    lane_ctrl.wr_data  = cmd_wval_r;
  end

  // The left and right halo columns act as the outer neighbors of the edge lanes.
  always_comb begin
    left_halo_nbr.above  = halo_bit(halo_r[EDGE_LEFT], int'(row_cnt_r) - 1);
    left_halo_nbr.cur    = halo_bit(halo_r[EDGE_LEFT], int'(row_cnt_r));
    left_halo_nbr.below  = halo_bit(halo_r[EDGE_LEFT], int'(row_cnt_r) + 1);
    right_halo_nbr.above = halo_bit(halo_r[EDGE_RIGHT], int'(row_cnt_r) - 1);
    right_halo_nbr.cur   = halo_bit(halo_r[EDGE_RIGHT], int'(row_cnt_r));
    right_halo_nbr.below = halo_bit(halo_r[EDGE_RIGHT], int'(row_cnt_r) + 1);
  end

  for (genvar c = 0; c < BOARD_SIDE; c++) begin : g_lane
    nbr_t left_in;
    nbr_t right_in;
    if (c == 0) begin : g_left_edge
      assign left_in = left_halo_nbr;
    end else begin : g_left_inner
      assign left_in = lane_nbr[c-1];
    end
    if (c == BOARD_SIDE - 1) begin : g_right_edge
      assign right_in = right_halo_nbr;
    end else begin : g_right_inner
      assign right_in = lane_nbr[c+1];
    end

    hltg_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (lane_ctrl),
      .wr_en       (wr_go && (int'(cmd_col_r) == c)),
      .left_nbr    (left_in),
      .right_nbr   (right_in),
      .top_halo    (halo_bit(halo_r[EDGE_TOP], c)),
      .bottom_halo (halo_bit(halo_r[EDGE_BOTTOM], c)),
      .own_nbr     (lane_nbr[c]),
      .rd_value    (lane_rd[c]),
      .tail_value  (lane_tail[c]),
      .live        (lane_live[c])
    );
  end

  // The tails hold the row finished in the previous cycle; their sum feeds the total.
  always_comb begin
    tail_sum = '0;
    any_live = 1'b0;
    for (int c = 0; c < BOARD_SIDE; c++) begin
      tail_sum = tail_sum + SUM_W'(lane_tail[c]);
      any_live = any_live | (|lane_live[c]);
    end
  end

  // Outgoing edge masks keep at most the low edge width of the board.
  always_comb begin
    edge_top    = '0;
    edge_right  = '0;
    edge_bottom = '0;
    edge_left   = '0;
    for (int i = 0; i < EDGE_W; i++) begin
      if (i < BOARD_SIDE) begin
        edge_top[i]    = lane_live[i][0];
        edge_bottom[i] = lane_live[i][BOARD_SIDE-1];
        edge_left[i]   = lane_live[0][i];
        edge_right[i]  = lane_live[BOARD_SIDE-1][i];
      end
    end
  end

  // A read outside the board, and every other operation, reports zero.
  assign rd_sel = (cmd_op_r == OP_READ && addr_ok) ? lane_rd[ROW_W'(cmd_col_r)] : '0;

  assign sum_same = (acc_r == prior_r);

  always_comb begin
    state_nxt   = state_r;
    row_cnt_nxt = row_cnt_r;
    acc_nxt     = acc_r;
    prior_nxt   = prior_r;
    steady_nxt  = steady_r;
    gen_nxt     = gen_r;
    bsum_nxt    = bsum_r;
    cleared_nxt = cleared_r;
    for (int e = 0; e < 4; e++) halo_nxt[e] = halo_r[e];
    lane_clear  = 1'b0;
    lane_shift  = 1'b0;
    wr_go       = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt   = ST_RESULT;
        bsum_nxt    = '0;
        cleared_nxt = 1'b0;
        unique case (cmd_op_r)
          OP_WRITE: wr_go = addr_ok;
          OP_HALO: begin
            // Reversal follows the mask in force when the edge is loaded.
            halo_nxt[cmd_esel_r] = reverse_r[cmd_esel_r] ? flip_edge(cmd_ebits_r)
                                                         : cmd_ebits_r;
          end
          OP_STEP: begin
            row_cnt_nxt = '0;
            acc_nxt     = '0;
            state_nxt   = ST_STEP;
          end
          OP_CLEAR: begin
            lane_clear = 1'b1;
            prior_nxt  = '0;
            steady_nxt = '0;
            gen_nxt    = '0;
          end
          default: ;
        endcase
      end
      ST_STEP: begin
        lane_shift = 1'b1;
        if (row_cnt_r != '0) acc_nxt = acc_r + tail_sum;
        if (row_cnt_r == ROW_LAST) begin
          state_nxt = ST_SUM;
        end else begin
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end
      ST_SUM: begin
        acc_nxt   = acc_r + tail_sum;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = ST_RESULT;
        bsum_nxt  = BSUM_W'(acc_r);
        if (sum_same) begin
          if (steady_r != '1) steady_nxt = steady_r + 1'b1;
        end else begin
          steady_nxt = '0;
          prior_nxt  = acc_r;
        end
        if (gen_r != '1) gen_nxt = gen_r + 1'b1;
        // Extinction or a long run of unchanged sums restarts the whole history.
        if (acc_r == '0 || steady_nxt > stasis_r) begin
          lane_clear  = 1'b1;
          gen_nxt     = '0;
          prior_nxt   = '0;
          steady_nxt  = '0;
          cleared_nxt = 1'b1;
        end
        // Running past the generation limit clears only the cells and the count.
        if (gen_nxt > gen_limit_r) begin
          lane_clear  = 1'b1;
          gen_nxt     = '0;
          cleared_nxt = 1'b1;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_cnt_r <= '0;
      acc_r     <= '0;
      prior_r   <= '0;
      steady_r  <= '0;
      gen_r     <= '0;
      bsum_r    <= '0;
      cleared_r <= 1'b0;
      for (int e = 0; e < 4; e++) halo_r[e] <= '0;
    end else begin
      state_r   <= state_nxt;
      row_cnt_r <= row_cnt_nxt;
      acc_r     <= acc_nxt;
      prior_r   <= prior_nxt;
      steady_r  <= steady_nxt;
      gen_r     <= gen_nxt;
      bsum_r    <= bsum_nxt;
      cleared_r <= cleared_nxt;
      for (int e = 0; e < 4; e++) halo_r[e] <= halo_nxt[e];
    end
  end

  // Command capture on an input transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_op_r    <= op_t'(in_tuser);
      cmd_col_r   <= in_tdata[2:0];
      cmd_row_r   <= in_tdata[5:3];
      cmd_wval_r  <= in_tdata[10:6];
      cmd_esel_r  <= in_tdata[12:11];
      cmd_ebits_r <= in_tdata[20:13];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highlife_r  <= 1'b1;
      mono_r      <= 1'b0;
      stasis_r    <= STASIS_RESET;
      gen_limit_r <= GEN_LIM_RESET;
      reverse_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HIGHLIFE: highlife_r  <= cfg_data[0];
        CFG_MONO:     mono_r      <= cfg_data[0];
        CFG_STASIS:   stasis_r    <= cfg_data[STEADY_W-1:0];
        CFG_GEN_LIM:  gen_limit_r <= cfg_data[GEN_W-1:0];
        CFG_REVERSE:  reverse_r   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Result register: loads when the slot is free or is being emptied this cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, edge_left, edge_bottom, edge_right, edge_top,
                     cleared_r, steady_r, bsum_r, rd_sel};
    end
  end

  // A clear decided at the end of a step leaves no live cell behind.
  a_step_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && lane_clear) |=> !any_live)
    else $error("board not empty after a step clear");

  // The generation count never stays above its limit once a step is closed.
  a_gen_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && $past(state_r == ST_DECIDE)) |-> (gen_r <= gen_limit_r))
    else $error("generation count above its limit after a step");

  // Likewise the steady count never stays above the stasis limit.
  a_steady_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && $past(state_r == ST_DECIDE)) |-> (steady_r <= stasis_r))
    else $error("steady count above the stasis limit after a step");

  // The row sweep ends after the last row and hands over to the sum stage.
  a_sweep_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP && row_cnt_r == ROW_LAST) |=> (state_r == ST_SUM))
    else $error("row sweep did not end after the last row");

endmodule
